@@ src/rf_unwrapped_timing_histogrammer_assert.svh @@
// Assertion macros for the RF-unwrapped timing histogrammer.
`ifndef RF_UNWRAPPED_TIMING_HISTOGRAMMER_ASSERT_SVH
`define RF_UNWRAPPED_TIMING_HISTOGRAMMER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RFUTH_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rfuth assertion failed");

// Next-cycle implication, disabled during reset.
`define RFUTH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rfuth assertion failed");

`endif

@@ src/rfuth_pkg.sv @@
// ---------------------------------------------------------------------------
// rfuth_pkg
// Shared constants, codes and types of the RF-unwrapped timing histogrammer.
// ---------------------------------------------------------------------------
package rfuth_pkg;

  localparam int POSITIONS_DEF = 16;
  localparam int CORES_DEF     = 4;

  localparam int TIME_BINS  = 32768;
  localparam int RF_BINS    = 4096;
  localparam int COUNT_BITS = 32;

  localparam int TB_W  = $clog2(TIME_BINS);
  localparam int RB_W  = $clog2(RF_BINS);
  localparam int PER_W = 12;
  localparam int PH_W  = 13;
  localparam int SH_W  = 15;
  localparam int DVD_W = 25;

  typedef enum logic [1:0] {
    OP_ACC     = 2'd0,
    OP_RD_TIME = 2'd1,
    OP_RD_RF   = 2'd2,
    OP_NOP     = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    REG_RF_PERIOD    = 2'd0,
    REG_PHASE_OFFSET = 2'd1,
    REG_CFD_SHIFT    = 2'd2,
    REG_NONE         = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic t_rd;
    logic t_wr;
    logic r_rd;
    logic r_wr;
  } hist_req_t;

  function automatic int ch_width(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

@@ src/rfuth_div.sv @@
// ---------------------------------------------------------------------------
// rfuth_div
// Restoring remainder unit, one dividend bit per cycle.
// ---------------------------------------------------------------------------
module rfuth_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [rfuth_pkg::DVD_W-1:0]     dividend,
  input  logic [rfuth_pkg::PER_W-1:0]     divisor,
  output logic                            done,
  output logic [rfuth_pkg::PER_W-1:0]     remainder
);
  import rfuth_pkg::*;

  localparam int CNT_W = $clog2(DVD_W);

  logic              run_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DVD_W-1:0]  dvd_r;
  logic [PER_W-1:0]  div_r;
  logic [PER_W-1:0]  rem_r;
  logic [PER_W:0]    shifted;
  logic [PER_W-1:0]  rem_nxt;

  always_comb begin
    shifted = {rem_r, dvd_r[DVD_W-1]};
    if (shifted >= {1'b0, div_r}) begin
      rem_nxt = PER_W'(shifted - {1'b0, div_r});
    end else begin
      rem_nxt = PER_W'(shifted);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CNT_W'(DVD_W - 1);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      div_r <= divisor;
      rem_r <= '0;
    end else if (run_r) begin
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

@@ src/rfuth_hist_mem.sv @@
// ---------------------------------------------------------------------------
// rfuth_hist_mem
// Time and RF histogram memories with a clearing pass after reset.
// ---------------------------------------------------------------------------
module rfuth_hist_mem #(
  parameter int POSITIONS = rfuth_pkg::POSITIONS_DEF,
  parameter int CORES     = rfuth_pkg::CORES_DEF,
  localparam int NCH      = POSITIONS * CORES,
  localparam int CH_W     = rfuth_pkg::ch_width(NCH),
  localparam int TA_W     = CH_W + rfuth_pkg::TB_W,
  localparam int RA_W     = CH_W + rfuth_pkg::RB_W
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  rfuth_pkg::hist_req_t              req,
  input  logic [TA_W-1:0]                   t_addr,
  input  logic [RA_W-1:0]                   r_addr,
  input  logic [rfuth_pkg::COUNT_BITS-1:0]  t_wdata,
  input  logic [rfuth_pkg::COUNT_BITS-1:0]  r_wdata,
  output logic [rfuth_pkg::COUNT_BITS-1:0]  t_rdata,
  output logic [rfuth_pkg::COUNT_BITS-1:0]  r_rdata,
  output logic                              busy
);
  import rfuth_pkg::*;

  localparam int TDEPTH = NCH * TIME_BINS;
  localparam int RDEPTH = NCH * RF_BINS;

  logic [COUNT_BITS-1:0] t_mem [TDEPTH];
  logic [COUNT_BITS-1:0] r_mem [RDEPTH];

  logic                  clr_r;
  logic [TA_W-1:0]       clr_cnt_r;
  logic                  clr_r_hit;
  logic [COUNT_BITS-1:0] t_rdata_r;
  logic [COUNT_BITS-1:0] r_rdata_r;

  assign clr_r_hit = ({1'b0, clr_cnt_r} < (TA_W + 1)'(RDEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
    end else if (clr_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == TA_W'(TDEPTH - 1)) begin
        clr_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_r) begin
      t_mem[clr_cnt_r] <= '0;
    end else if (req.t_wr) begin
      t_mem[t_addr] <= t_wdata;
    end
    if (req.t_rd) begin
      t_rdata_r <= t_mem[t_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (clr_r && clr_r_hit) begin
      r_mem[clr_cnt_r[RA_W-1:0]] <= '0;
    end else if (!clr_r && req.r_wr) begin
      r_mem[r_addr] <= r_wdata;
    end
    if (req.r_rd) begin
      r_rdata_r <= r_mem[r_addr];
    end
  end

  assign t_rdata = t_rdata_r;
  assign r_rdata = r_rdata_r;
  assign busy    = clr_r;

endmodule

@@ src/rf_unwrapped_timing_histogrammer.sv @@
// ---------------------------------------------------------------------------
// rf_unwrapped_timing_histogrammer
// Per-channel time and RF histograms of detector hits with RF unwrapping.
// ---------------------------------------------------------------------------
// One transaction is handled at a time. An accumulate with RF and a nonzero
// period passes prep, the 25-step remainder unit (raw time plus shift,
// remainder by the RF period), unwrap, RF bin, time bin, read, write back
// and done; an accumulate with RF and a zero period skips the remainder
// unit, one without RF starts at the time bin, a read runs read, write back
// and done, and an unused opcode or a channel out of range goes to done.
// The input is ready again in the cycle the result is presented, so the
// next transaction can be accepted in that same cycle; a stalled result
// holds the block in its last state. Histogram updates are a read, a
// saturating increment and a write back in synchronous memories. After
// reset both memories are swept to zero, one entry per cycle; no input
// transaction is taken during the sweep, configuration writes are.
// ---------------------------------------------------------------------------
module rf_unwrapped_timing_histogrammer #(
  parameter int POSITIONS = rfuth_pkg::POSITIONS_DEF,
  parameter int CORES     = rfuth_pkg::CORES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_opcode,
  input  logic [3:0]         in_position,
  input  logic [1:0]         in_core,
  input  logic [23:0]        in_cfd_time,
  input  logic [19:0]        in_timestamp_low,
  input  logic               in_rf_valid,
  input  logic signed [15:0] in_rf_time,
  input  logic [14:0]        in_bin_index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        out_read_count,
  output logic [14:0]        out_time_bin,
  output logic [11:0]        out_rf_bin,
  output logic               out_rf_used,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [14:0]        cfg_data
);
  import rfuth_pkg::*;

  localparam int NCH  = POSITIONS * CORES;
  localparam int CH_W = ch_width(NCH);
  localparam int TA_W = CH_W + TB_W;
  localparam int RA_W = CH_W + RB_W;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_PREP   = 9'b000000010,
    S_DIV    = 9'b000000100,
    S_UNWRAP = 9'b000001000,
    S_RBIN   = 9'b000010000,
    S_TBIN   = 9'b000100000,
    S_RD     = 9'b001000000,
    S_WB     = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic [PER_W-1:0]        rf_period_r;
  logic signed [PH_W-1:0]  phase_offset_r;
  logic signed [SH_W-1:0]  cfd_shift_r;

  opcode_t                 op_r;
  logic [CH_W-1:0]         ch_r;
  logic signed [24:0]      t_r;
  logic                    rfv_r;
  logic signed [18:0]      q_r;
  logic [TB_W-1:0]         bin_r;
  logic                    neg_r;
  logic signed [PH_W-1:0]  a_r;
  logic [COUNT_BITS-1:0]   count_r;
  logic [TB_W-1:0]         tbin_r;
  logic [RB_W-1:0]         rbin_r;
  logic                    used_r;

  logic                    out_valid_r;
  logic [COUNT_BITS-1:0]   out_count_r;
  logic [TB_W-1:0]         out_tbin_r;
  logic [RB_W-1:0]         out_rbin_r;
  logic                    out_used_r;

  logic                    in_acc;
  logic                    ch_ok;
  logic [CH_W-1:0]         ch_in;
  logic signed [24:0]      t_in;
  logic signed [25:0]      s_val;
  logic [DVD_W-1:0]        s_mag;
  logic                    div_start;
  logic                    div_done;
  logic [PER_W-1:0]        div_rem;
  logic signed [13:0]      pp;
  logic signed [19:0]      lhs;
  logic signed [19:0]      rhs;
  logic [14:0]             ip;
  logic [14:0]             ipr;
  logic [RB_W-1:0]         r_val;
  logic signed [26:0]      tt;
  logic [TB_W-1:0]         tbin_val;
  logic                    t_in_range;
  logic                    r_in_range;
  hist_req_t               req;
  logic [TA_W-1:0]         t_addr;
  logic [RA_W-1:0]         r_addr;
  logic [COUNT_BITS-1:0]   t_rdata;
  logic [COUNT_BITS-1:0]   r_rdata;
  logic [COUNT_BITS-1:0]   t_inc;
  logic [COUNT_BITS-1:0]   r_inc;
  logic                    mem_busy;

  assign in_ready  = (state_r == S_IDLE) && !mem_busy;
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign ch_ok = (32'(in_position) < POSITIONS) && (32'(in_core) < CORES);
  assign ch_in = CH_W'(32'(in_position) * CORES + 32'(in_core));
  assign t_in  = $signed({1'b0, in_cfd_time}) - $signed({1'b0, in_timestamp_low, 4'b0000});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_period_r    <= PER_W'(1);
      phase_offset_r <= '0;
      cfd_shift_r    <= '0;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_RF_PERIOD:    rf_period_r    <= cfg_data[PER_W-1:0];
        REG_PHASE_OFFSET: phase_offset_r <= $signed(cfg_data[PH_W-1:0]);
        REG_CFD_SHIFT:    cfd_shift_r    <= $signed(cfg_data[SH_W-1:0]);
        REG_NONE:         ;
      endcase
    end
  end

  assign s_val     = 26'(t_r) + 26'(cfd_shift_r);
  assign s_mag     = s_val[25] ? DVD_W'(-s_val) : DVD_W'(s_val);
  assign div_start = (state_r == S_PREP) && (rf_period_r != '0);

  rfuth_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (s_mag),
    .divisor   (rf_period_r),
    .done      (div_done),
    .remainder (div_rem)
  );

  assign pp  = $signed({2'b00, rf_period_r}) + 14'(phase_offset_r);
  assign lhs = 20'(q_r) - (20'(pp) <<< 4);
  assign rhs = 20'(a_r) <<< 4;

  always_comb begin
    ip  = 15'(q_r[18:4]);
    ipr = ip;
    if ((q_r[3:0] > 4'd8) || ((q_r[3:0] == 4'd8) && ip[0])) begin
      ipr = ip + 15'd1;
    end
    if ((q_r < 0) || (q_r > $signed(19'(RF_BINS * 16))) || (32'(ipr) >= RF_BINS)) begin
      r_val = RB_W'(RF_BINS - 100);
    end else begin
      r_val = ipr[RB_W-1:0];
    end
  end

  assign tt = 27'(t_r) - $signed({15'd0, rbin_r}) + $signed(27'(TIME_BINS / 2));

  always_comb begin
    priority if (!rfv_r) begin
      tbin_val = TB_W'(TIME_BINS - 400);
    end else if (tt < 0) begin
      tbin_val = TB_W'(TIME_BINS - 200);
    end else if (tt >= $signed(27'(TIME_BINS))) begin
      tbin_val = TB_W'(TIME_BINS - 300);
    end else begin
      tbin_val = tt[TB_W-1:0];
    end
  end

  assign t_in_range = (32'(bin_r) < TIME_BINS);
  assign r_in_range = (32'(bin_r) < RF_BINS);

  always_comb begin
    if (op_r == OP_ACC) begin
      t_addr = {ch_r, tbin_r};
      r_addr = {ch_r, rbin_r};
    end else begin
      t_addr = {ch_r, bin_r};
      r_addr = {ch_r, bin_r[RB_W-1:0]};
    end
  end

  assign t_inc = (t_rdata == '1) ? t_rdata : t_rdata + 1'b1;
  assign r_inc = (r_rdata == '1) ? r_rdata : r_rdata + 1'b1;

  always_comb begin
    req      = '0;
    req.t_rd = (state_r == S_RD) && (op_r != OP_RD_RF);
    req.r_rd = (state_r == S_RD) && (op_r != OP_RD_TIME);
    req.t_wr = (state_r == S_WB) && (op_r == OP_ACC);
    req.r_wr = (state_r == S_WB) && (op_r == OP_ACC) && used_r;
  end

  rfuth_hist_mem #(
    .POSITIONS (POSITIONS),
    .CORES     (CORES)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .t_addr  (t_addr),
    .r_addr  (r_addr),
    .t_wdata (t_inc),
    .r_wdata (r_inc),
    .t_rdata (t_rdata),
    .r_rdata (r_rdata),
    .busy    (mem_busy)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (!ch_ok || (opcode_t'(in_opcode) == OP_NOP)) begin
            state_nxt = S_DONE;
          end else if (opcode_t'(in_opcode) != OP_ACC) begin
            state_nxt = S_RD;
          end else if (in_rf_valid) begin
            state_nxt = S_PREP;
          end else begin
            state_nxt = S_TBIN;
          end
        end
      end
      S_PREP:   state_nxt = (rf_period_r != '0) ? S_DIV : S_UNWRAP;
      S_DIV:    state_nxt = div_done ? S_UNWRAP : S_DIV;
      S_UNWRAP: state_nxt = S_RBIN;
      S_RBIN:   state_nxt = S_TBIN;
      S_TBIN:   state_nxt = S_RD;
      S_RD:     state_nxt = S_WB;
      S_WB:     state_nxt = S_DONE;
      S_DONE:   state_nxt = (!out_valid_r || out_ready) ? S_IDLE : S_DONE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_r    <= opcode_t'(in_opcode);
          ch_r    <= ch_in;
          t_r     <= t_in;
          rfv_r   <= in_rf_valid;
          q_r     <= 19'(in_rf_time);
          bin_r   <= in_bin_index;
          count_r <= '0;
          tbin_r  <= '0;
          rbin_r  <= '0;
          used_r  <= 1'b0;
        end
      end
      S_PREP: begin
        neg_r <= s_val[25];
        a_r   <= '0;
      end
      S_DIV: begin
        if (div_done) begin
          a_r <= neg_r ? -$signed({1'b0, div_rem}) : $signed({1'b0, div_rem});
        end
      end
      S_UNWRAP: begin
        if (lhs < rhs) begin
          q_r <= q_r + $signed({3'b000, rf_period_r, 4'b0000});
        end
      end
      S_RBIN: begin
        rbin_r <= r_val;
        used_r <= 1'b1;
      end
      S_TBIN: begin
        tbin_r <= tbin_val;
      end
      S_WB: begin
        if (op_r == OP_RD_TIME) begin
          count_r <= t_in_range ? t_rdata : '0;
        end else if (op_r == OP_RD_RF) begin
          count_r <= r_in_range ? r_rdata : '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_DONE) && (!out_valid_r || out_ready)) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_DONE) && (!out_valid_r || out_ready)) begin
      out_count_r <= count_r;
      out_tbin_r  <= tbin_r;
      out_rbin_r  <= rbin_r;
      out_used_r  <= used_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_count = out_count_r;
  assign out_time_bin   = out_tbin_r;
  assign out_rf_bin     = out_rbin_r;
  assign out_rf_used    = out_used_r;

endmodule

@@ src/rfuth_checker.sv @@
// ---------------------------------------------------------------------------
// rfuth_checker
// Port-level checks of the RF-unwrapped timing histogrammer.
// ---------------------------------------------------------------------------
`include "rf_unwrapped_timing_histogrammer_assert.svh"

module rfuth_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_read_count,
  input logic [14:0] out_time_bin,
  input logic [11:0] out_rf_bin,
  input logic        out_rf_used
);

  `RFUTH_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_read_count) && $stable(out_time_bin) && $stable(out_rf_bin) && $stable(out_rf_used))
  `RFUTH_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready)
  `RFUTH_ASSERT_NOW(a_no_rf_bin, clk, rst_n, out_valid && !out_rf_used, out_rf_bin == 12'd0)
  `RFUTH_ASSERT_NOW(a_read_no_bins, clk, rst_n, out_valid && (out_read_count != 32'd0), (out_time_bin == 15'd0) && !out_rf_used)

endmodule

bind rf_unwrapped_timing_histogrammer rfuth_checker u_rfuth_checker (.*);
